@@ sv/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, codes and small helpers for the seriated Playfair cipher core.
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] func_t;

  localparam func_t FUNC_BEGIN  = 3'd0;
  localparam func_t FUNC_KEY    = 3'd1;
  localparam func_t FUNC_FINISH = 3'd2;
  localparam func_t FUNC_TEXT   = 3'd3;
  localparam func_t FUNC_END    = 3'd4;

  localparam logic REG_DECRYPT = 1'b0;
  localparam logic REG_PERIOD  = 1'b1;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_X    = 5'd23;
  localparam letter_t LETTER_LAST = 5'd25;
  localparam letter_t SQ_FULL     = 5'd25;

  localparam int unsigned SQ_DEPTH  = 25;
  localparam int unsigned POS_DEPTH = 26;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic accept;
    logic walk;
    logic sq_read;
    logic out_load;
  } spc_cmd_t;

  typedef struct packed {
    logic pair_start;
    logic walk_start;
    logic walk_last;
  } spc_status_t;

  function automatic pos_t fill_pos(input letter_t idx);
    pos_t    p;
    letter_t base;
    if (idx >= 5'd20) begin
      p.row = 3'd4;
      base  = 5'd20;
    end else if (idx >= 5'd15) begin
      p.row = 3'd3;
      base  = 5'd15;
    end else if (idx >= 5'd10) begin
      p.row = 3'd2;
      base  = 5'd10;
    end else if (idx >= 5'd5) begin
      p.row = 3'd1;
      base  = 5'd5;
    end else begin
      p.row = 3'd0;
      base  = 5'd0;
    end
    p.col = 3'(idx - base);
    return p;
  endfunction

  function automatic logic [2:0] shift5(input logic [2:0] v, input logic back);
    logic [2:0] r;
    if (back) begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

  function automatic letter_t sq_addr(input pos_t p);
    return {p.row, 2'b00} + {2'b00, p.row} + {2'b00, p.col};
  endfunction

endpackage

@@ sv/spc_ram.sv @@
// ----------------------------------------------------------------------------
// spc_ram
// Generic RAM: one write port, two read ports with registered, enabled reads.
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ sv/spc_ctrl.sv @@
// ----------------------------------------------------------------------------
// spc_ctrl
// Sequencer: accepts transactions, runs the key walk and the pair lookup.
// ----------------------------------------------------------------------------
module spc_ctrl
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  spc_status_t status,
  output spc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LOOKUP,
    S_SQUARE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.accept   = in_valid && in_ready;
    cmd.walk     = (state == S_WALK);
    cmd.sq_read  = (state == S_LOOKUP);
    cmd.out_load = (state == S_SQUARE) && (!out_valid || out_ready);
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          if (status.walk_start) begin
            state_next = S_WALK;
          end else if (status.pair_start) begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_WALK: begin
        if (status.walk_last) begin
          state_next = S_IDLE;
        end
      end
      S_LOOKUP: begin
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        if (cmd.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/spc_datapath.sv @@
// ----------------------------------------------------------------------------
// spc_datapath
// Key square, position table, key and text state, pair transform and output.
// ----------------------------------------------------------------------------
module spc_datapath
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  func,
  input  logic [4:0]  letter,
  input  logic        decrypt_mode,
  input  logic [7:0]  group_period,
  input  spc_cmd_t    cmd,
  output spc_status_t status,
  output logic [4:0]  first_letter,
  output logic [4:0]  second_letter
);

  logic [25:0] used;
  letter_t     fill;
  logic        key_ready;
  logic [7:0]  group_count;
  letter_t     held_letter;
  logic        held_valid;
  letter_t     walk_idx;

  letter_t     letter_m;
  logic        letter_ok;
  logic [7:0]  period;
  logic [7:0]  group_count_inc;
  logic        group_end;
  logic        text_ok;
  logic        key_wr;
  logic        walk_wr;
  letter_t     pair_a;
  letter_t     pair_b;

  logic        sq_we;
  letter_t     sq_wdata;
  logic        pos_we;
  letter_t     pos_waddr;
  logic [5:0]  pos_rd0;
  logic [5:0]  pos_rd1;
  pos_t        pos_a;
  pos_t        pos_b;
  pos_t        sel_a;
  pos_t        sel_b;
  letter_t     sq_rd0;
  letter_t     sq_rd1;

  always_comb begin
    letter_m        = (letter == LETTER_J) ? LETTER_I : letter;
    letter_ok       = (letter_m <= LETTER_LAST);
    period          = (group_period < 8'd2) ? 8'd2 : group_period;
    group_count_inc = group_count + 8'd1;
    group_end       = (group_count_inc >= period);
    text_ok         = key_ready && letter_ok;
    key_wr          = cmd.accept && (func == FUNC_KEY) && !key_ready && letter_ok
                      && (fill < SQ_FULL) && !used[letter_m];
    walk_wr         = (walk_idx != LETTER_J) && !used[walk_idx] && (fill < SQ_FULL);

    pair_a = ((func == FUNC_END) || held_valid) ? held_letter : letter_m;
    pair_b = ((func == FUNC_TEXT) && held_valid) ? letter_m : LETTER_X;

    status.walk_start = (func == FUNC_FINISH);
    status.walk_last  = (walk_idx == LETTER_LAST);
    unique case (func)
      FUNC_TEXT: status.pair_start = text_ok && (held_valid || (group_end && !decrypt_mode));
      FUNC_END:  status.pair_start = key_ready && held_valid && !decrypt_mode;
      default:   status.pair_start = 1'b0;
    endcase

    sq_we     = key_wr || (cmd.walk && walk_wr);
    sq_wdata  = cmd.walk ? walk_idx : letter_m;
    pos_we    = sq_we;
    pos_waddr = sq_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      fill        <= '0;
      key_ready   <= 1'b0;
      group_count <= '0;
      held_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        unique case (func)
          FUNC_BEGIN: begin
            used        <= '0;
            fill        <= '0;
            key_ready   <= 1'b0;
            group_count <= '0;
            held_valid  <= 1'b0;
          end
          FUNC_KEY: begin
            if (key_wr) begin
              used[letter_m] <= 1'b1;
              fill           <= fill + 5'd1;
            end
          end
          FUNC_FINISH: begin
            key_ready   <= 1'b1;
            group_count <= '0;
            held_valid  <= 1'b0;
            walk_idx    <= '0;
          end
          FUNC_TEXT: begin
            if (text_ok) begin
              group_count <= group_end ? 8'd0 : group_count_inc;
              held_valid  <= !held_valid && !group_end;
              if (!held_valid) begin
                held_letter <= letter_m;
              end
            end
          end
          FUNC_END: begin
            if (key_ready) begin
              group_count <= '0;
              held_valid  <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk) begin
        if (walk_wr) begin
          used[walk_idx] <= 1'b1;
          fill           <= fill + 5'd1;
        end
        walk_idx <= walk_idx + 5'd1;
      end
    end
  end

  spc_ram #(
    .WIDTH (6),
    .DEPTH (POS_DEPTH)
  ) u_pos_ram (
    .clk    (clk),
    .we     (pos_we),
    .waddr  (pos_waddr),
    .wdata  (fill_pos(fill)),
    .re     (cmd.accept),
    .raddr0 (pair_a),
    .raddr1 (pair_b),
    .rdata0 (pos_rd0),
    .rdata1 (pos_rd1)
  );

  always_comb begin
    pos_a = pos_rd0;
    pos_b = pos_rd1;
    if (pos_a.row == pos_b.row) begin
      sel_a.row = pos_a.row;
      sel_a.col = shift5(pos_a.col, decrypt_mode);
      sel_b.row = pos_b.row;
      sel_b.col = shift5(pos_b.col, decrypt_mode);
    end else if (pos_a.col == pos_b.col) begin
      sel_a.row = shift5(pos_a.row, decrypt_mode);
      sel_a.col = pos_a.col;
      sel_b.row = shift5(pos_b.row, decrypt_mode);
      sel_b.col = pos_b.col;
    end else begin
      sel_a.row = pos_a.row;
      sel_a.col = pos_b.col;
      sel_b.row = pos_b.row;
      sel_b.col = pos_a.col;
    end
  end

  spc_ram #(
    .WIDTH (5),
    .DEPTH (SQ_DEPTH)
  ) u_square_ram (
    .clk    (clk),
    .we     (sq_we),
    .waddr  (fill),
    .wdata  (sq_wdata),
    .re     (cmd.sq_read),
    .raddr0 (sq_addr(sel_a)),
    .raddr1 (sq_addr(sel_b)),
    .rdata0 (sq_rd0),
    .rdata1 (sq_rd1)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      first_letter  <= sq_rd0;
      second_letter <= sq_rd1;
    end
  end

endmodule

@@ sv/seriated_playfair_cipher_core.sv @@
// ----------------------------------------------------------------------------
// seriated_playfair_cipher_core
// Seriated Playfair cipher over a 5x5 key square with J folded into I.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    func, letter
//   out      out_valid/out_ready  first_letter, second_letter
//   cfg      APB psel/penable     paddr, pwdata, prdata (decrypt_mode, group_period)
//
// Begin key, key letter and text letters that yield no pair leave the
// sequencer idle. A pair passes the position table read, then the key square
// read, then the output register. Finish key starts a letter walk that
// fills the square. Reset is synchronous; no clearing pass is needed. A full
// output register holds a finished pair; input is still taken until the next
// pair reaches the output stage, which then stalls input until out_ready.
// ----------------------------------------------------------------------------
module seriated_playfair_cipher_core
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [4:0]  letter,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  first_letter,
  output logic [4:0]  second_letter,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        decrypt_mode;
  logic [7:0]  group_period;
  spc_cmd_t    cmd;
  spc_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      group_period <= 8'd2;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_DECRYPT: decrypt_mode <= pwdata[0];
        REG_PERIOD:  group_period <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DECRYPT: prdata = {31'b0, decrypt_mode};
      REG_PERIOD:  prdata = {24'b0, group_period};
      default:     prdata = '0;
    endcase
  end

  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  spc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .func          (func),
    .letter        (letter),
    .decrypt_mode  (decrypt_mode),
    .group_period  (group_period),
    .cmd           (cmd),
    .status        (status),
    .first_letter  (first_letter),
    .second_letter (second_letter)
  );

endmodule
